FILE: hw/rtl/text_console_writer_assert.svh
// ----------------------------------------------------------------------------
// text_console_writer_assert.svh
// assertion macros used by the checker of the text console writer
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define TCW_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define TCW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// shared constants, codes and controller/datapath types of the text console
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = COLUMNS * ROWS;

	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;
	localparam int ADDR_W = 11;
	localparam int BYTE_W = 8;

	// cells moved by a scroll, and end of the row blanked after it
	localparam int COPY_N    = (ROWS - 2) * COLUMNS;
	localparam int BLANK_END = (ROWS - 1) * COLUMNS;

	localparam logic [BYTE_W-1:0] CH_BACKSPACE = 8'h08;
	localparam logic [BYTE_W-1:0] CH_CR        = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_LF        = 8'h0A;
	localparam logic [BYTE_W-1:0] ATTR_RESET   = 8'h0F;

	typedef enum logic [1:0] {
		OP_PUT   = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2
	} opcode_t;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_EXEC,
		S_COPY,
		S_BLANK,
		S_RESP
	} state_t;

	typedef enum logic [2:0] {
		DP_NONE,
		DP_INIT,
		DP_EXEC,
		DP_COPY,
		DP_BLANK
	} dp_op_t;

	typedef struct packed {
		logic   latch;
		dp_op_t op;
	} tcw_cmd_t;

	typedef struct packed {
		opcode_t opcode;
		logic    scroll_req;
		logic    copy_end;
		logic    blank_end;
		logic    init_end;
	} tcw_status_t;

endpackage

FILE: hw/rtl/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module tcw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: hw/rtl/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl
// sequencing state machine: clearing pass, execute, scroll copy, blank, respond
// ----------------------------------------------------------------------------
module tcw_ctrl import tcw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  tcw_status_t status,
	output tcw_cmd_t    cmd,
	output logic        busy,
	output logic        done
);

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx  = state_q;
		cmd.latch = 1'b0;
		cmd.op    = DP_NONE;
		busy      = 1'b1;
		done      = 1'b0;
		case (state_q)
			S_INIT: begin
				cmd.op = DP_INIT;
				if (status.init_end) begin
					state_nx = S_IDLE;
				end
			end
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.latch = 1'b1;
					state_nx  = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.op = DP_EXEC;
				case (status.opcode)
					OP_PUT:   state_nx = status.scroll_req ? S_COPY : S_RESP;
					OP_CLEAR: state_nx = S_BLANK;
					default:  state_nx = S_RESP;
				endcase
			end
			S_COPY: begin
				cmd.op = DP_COPY;
				if (status.copy_end) begin
					state_nx = S_BLANK;
				end
			end
			S_BLANK: begin
				cmd.op = DP_BLANK;
				if (status.blank_end) begin
					state_nx = S_RESP;
				end
			end
			S_RESP: begin
				busy = 1'b0;
				done = 1'b1;
				if (start) begin
					cmd.latch = 1'b1;
					state_nx  = S_EXEC;
				end else begin
					state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_INIT;
			end
		endcase
	end

endmodule

FILE: hw/rtl/tcw_datapath.sv
// ----------------------------------------------------------------------------
// tcw_datapath
// cursor, attribute register, sweep counter and the character/attribute rams
// ----------------------------------------------------------------------------
module tcw_datapath import tcw_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  tcw_cmd_t           cmd,
	output tcw_status_t        status,
	input  logic [1:0]         opcode,
	input  logic [BYTE_W-1:0]  char_code,
	input  logic [ADDR_W-1:0]  cell_index,
	input  logic               cfg_we,
	input  logic [BYTE_W-1:0]  cfg_wdata,
	output logic [COL_W-1:0]   cursor_col,
	output logic [ROW_W-1:0]   cursor_row,
	output logic [ADDR_W-1:0]  cursor_position,
	output logic [BYTE_W-1:0]  cell_char,
	output logic [BYTE_W-1:0]  cell_attr,
	output logic               scrolled
);

	opcode_t            op_q;
	logic [BYTE_W-1:0]  ch_q;
	logic [ADDR_W-1:0]  idx_q;
	logic [BYTE_W-1:0]  text_attr_q;
	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;
	logic [ADDR_W-1:0]  cnt_q;
	logic               scrolled_q;

	logic [COL_W:0]     col_nx;
	logic [ROW_W:0]     row_nx;
	logic               scroll_req;
	logic [ADDR_W-1:0]  pos_cur;
	logic               idx_ok;

	logic               chr_we, atr_we;
	logic [ADDR_W-1:0]  waddr, raddr;
	logic [BYTE_W-1:0]  chr_wdata, atr_wdata, chr_rdata, atr_rdata;

	// payload capture
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q  <= opcode_t'(opcode);
			ch_q  <= char_code;
			idx_q <= cell_index;
		end
		if (cmd.op == DP_EXEC) begin
			scrolled_q <= (op_q == OP_PUT) && scroll_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_attr_q <= ATTR_RESET;
		end else if (cfg_we) begin
			text_attr_q <= cfg_wdata;
		end
	end

	assign pos_cur = ADDR_W'(int'(row_q) * COLUMNS + int'(col_q));
	assign idx_ok  = int'(idx_q) < CELLS;

	// put-character cursor update
	always_comb begin
		col_nx     = {1'b0, col_q};
		row_nx     = {1'b0, row_q};
		scroll_req = 1'b0;
		case (ch_q)
			CH_BACKSPACE: begin
				if (col_q != '0) begin
					col_nx = {1'b0, col_q} - 1'b1;
				end
			end
			CH_CR: begin
				col_nx = '0;
			end
			CH_LF: begin
				col_nx = '0;
				row_nx = {1'b0, row_q} + 1'b1;
			end
			default: begin
				col_nx = {1'b0, col_q} + 1'b1;
			end
		endcase
		if (col_nx >= (COL_W+1)'(COLUMNS)) begin
			col_nx = '0;
			row_nx = row_nx + 1'b1;
		end
		if (row_nx >= (ROW_W+1)'(ROWS - 1)) begin
			row_nx     = row_nx - 1'b1;
			scroll_req = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			cnt_q <= '0;
		end else begin
			case (cmd.op)
				DP_EXEC: begin
					cnt_q <= '0;
					case (op_q)
						OP_PUT: begin
							col_q <= col_nx[COL_W-1:0];
							row_q <= row_nx[ROW_W-1:0];
						end
						OP_CLEAR: begin
							col_q <= '0;
							row_q <= '0;
						end
						default: begin
						end
					endcase
				end
				DP_COPY: begin
					if (!status.copy_end) begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				DP_INIT, DP_BLANK: begin
					cnt_q <= cnt_q + 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// ram port control
	always_comb begin
		chr_we    = 1'b0;
		atr_we    = 1'b0;
		waddr     = cnt_q;
		chr_wdata = '0;
		atr_wdata = '0;
		raddr     = idx_ok ? idx_q : '0;
		case (cmd.op)
			DP_EXEC: begin
				if (op_q == OP_PUT) begin
					case (ch_q)
						CH_BACKSPACE: begin
							// clear the character left of the cursor, keep its attribute
							chr_we = (col_q != '0);
							waddr  = pos_cur - 1'b1;
						end
						CH_CR, CH_LF: begin
						end
						default: begin
							chr_we    = 1'b1;
							atr_we    = 1'b1;
							waddr     = pos_cur;
							chr_wdata = ch_q;
							atr_wdata = text_attr_q;
						end
					endcase
				end
			end
			DP_COPY: begin
				// read one row ahead, write the previous read one cell behind
				raddr     = cnt_q + ADDR_W'(COLUMNS);
				chr_we    = (cnt_q != '0);
				atr_we    = (cnt_q != '0);
				waddr     = cnt_q - 1'b1;
				chr_wdata = chr_rdata;
				atr_wdata = atr_rdata;
			end
			DP_INIT, DP_BLANK: begin
				chr_we = 1'b1;
				atr_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	tcw_ram #(.WIDTH(BYTE_W), .DEPTH(CELLS)) u_chars (
		.clk   (clk),
		.we    (chr_we),
		.waddr (waddr),
		.wdata (chr_wdata),
		.raddr (raddr),
		.rdata (chr_rdata)
	);

	tcw_ram #(.WIDTH(BYTE_W), .DEPTH(CELLS)) u_attrs (
		.clk   (clk),
		.we    (atr_we),
		.waddr (waddr),
		.wdata (atr_wdata),
		.raddr (raddr),
		.rdata (atr_rdata)
	);

	assign status.opcode     = op_q;
	assign status.scroll_req = scroll_req;
	assign status.copy_end   = (cnt_q == ADDR_W'(COPY_N));
	assign status.blank_end  = (cnt_q == ADDR_W'(BLANK_END - 1));
	assign status.init_end   = (cnt_q == ADDR_W'(CELLS - 1));

	assign cursor_col      = col_q;
	assign cursor_row      = row_q;
	assign cursor_position = pos_cur;
	assign cell_char       = (op_q == OP_READ && idx_ok) ? chr_rdata : '0;
	assign cell_attr       = (op_q == OP_READ && idx_ok) ? atr_rdata : '0;
	assign scrolled        = scrolled_q;

endmodule

FILE: hw/rtl/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer
// 80x25 character-cell console: put character, read cell, clear screen
// ----------------------------------------------------------------------------
// usage
//   request channel: a request is taken at a rising edge with start high and
//   busy low; opcode, char_code and cell_index are sampled at that edge
//   result channel: done is high for exactly one cycle with the cursor, the
//   read cell bytes and the scroll flag; the receiver cannot stall it
//   config: cfg_we writes cfg_wdata into the text attribute register at once
// sequence
//   put without scroll, read, unused opcode: an execute state, then done in
//   the respond state; start may be high during the done cycle, so these run
//   back to back
//   put with scroll: a one-cell-per-cycle row copy, then the blanking of one
//   row through one ram port
//   clear screen: one cell blanked per cycle
// reset
//   cursor goes home, attribute becomes 0x0f, and a clearing pass zeroes
//   every cell; busy stays high until it finishes
// ----------------------------------------------------------------------------
module text_console_writer import tcw_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// request
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         opcode,
	input  logic [BYTE_W-1:0]  char_code,
	input  logic [ADDR_W-1:0]  cell_index,
	// attribute register
	input  logic               cfg_we,
	input  logic [BYTE_W-1:0]  cfg_wdata,
	// result
	output logic               done,
	output logic [COL_W-1:0]   cursor_col,
	output logic [ROW_W-1:0]   cursor_row,
	output logic [ADDR_W-1:0]  cursor_position,
	output logic [BYTE_W-1:0]  cell_char,
	output logic [BYTE_W-1:0]  cell_attr,
	output logic               scrolled
);

	// command and status between sequencer and datapath
	tcw_cmd_t    cmd;
	tcw_status_t status;

	// sequencer: clearing pass, execute, scroll copy, blank, respond
	tcw_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// cursor, attribute register and screen rams
	tcw_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.opcode          (opcode),
		.char_code       (char_code),
		.cell_index      (cell_index),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.cursor_col      (cursor_col),
		.cursor_row      (cursor_row),
		.cursor_position (cursor_position),
		.cell_char       (cell_char),
		.cell_attr       (cell_attr),
		.scrolled        (scrolled)
	);

endmodule

FILE: hw/rtl/tcw_checker.sv
// ----------------------------------------------------------------------------
// tcw_checker
// port-level checks on the text console writer, bound to the top level
// ----------------------------------------------------------------------------
`include "text_console_writer_assert.svh"

module tcw_checker import tcw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  logic              done,
	input  logic [COL_W-1:0]  cursor_col,
	input  logic [ROW_W-1:0]  cursor_row,
	input  logic [ADDR_W-1:0] cursor_position,
	input  logic              scrolled
);

	logic accepted;
	logic in_range;
	logic pos_ok;
	logic scroll_ok;

	assign accepted  = start && !busy;
	assign in_range  = (int'(cursor_col) < COLUMNS) && (int'(cursor_row) < ROWS - 1);
	assign pos_ok    = int'(cursor_position) == int'(cursor_row) * COLUMNS + int'(cursor_col);
	assign scroll_ok = int'(cursor_row) == ROWS - 2;

	// an accepted request is worked on in the next cycle, never answered there
	`TCW_ASSERT_NEXT(a_accept_then_busy, clk, arst_n, accepted, busy && !done, "early answer")

	// at every done the cursor stays above the last row and inside the columns
	`TCW_ASSERT_SAME(a_cursor_range, clk, arst_n, done, in_range, "cursor out of range")

	// linear position agrees with row and column
	`TCW_ASSERT_SAME(a_position, clk, arst_n, done, pos_ok, "cursor position mismatch")

	// a scroll always leaves the cursor on the row above the last
	`TCW_ASSERT_SAME(a_scroll_row, clk, arst_n, done && scrolled, scroll_ok, "scroll row wrong")

endmodule

bind text_console_writer tcw_checker u_tcw_checker (.*);

FILE: bench/tb_text_console_writer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_writer
// self-checking bench for the 80x25 text console: put, read, clear, scroll
// ----------------------------------------------------------------------------
// each request is predicted against a local copy of the screen, the cursor and
// the attribute register; every done pulse is compared with the oldest
// prediction, field by field. a short directed run hits the corner cases,
// then weighted random traffic drives text, line feeds, wraps and scrolls
// ----------------------------------------------------------------------------
module tb_text_console_writer;
	import tcw_pkg::*;

	// opcode that the block must ignore
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// worst case: every request scrolls, gaps included, taken 4x over
	localparam int unsigned CYCLE_LIMIT = 12_000_000;
	localparam int unsigned TAIL_CYCLES = 2000;

	typedef struct packed {
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
		logic [ADDR_W-1:0] pos;
		logic [BYTE_W-1:0] chr;
		logic [BYTE_W-1:0] attr;
		logic              scr;
	} console_result_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         opcode;
	logic [BYTE_W-1:0]  char_code;
	logic [ADDR_W-1:0]  cell_index;
	logic               cfg_we;
	logic [BYTE_W-1:0]  cfg_wdata;
	logic               done;
	logic [COL_W-1:0]   cursor_col;
	logic [ROW_W-1:0]   cursor_row;
	logic [ADDR_W-1:0]  cursor_position;
	logic [BYTE_W-1:0]  cell_char;
	logic [BYTE_W-1:0]  cell_attr;
	logic               scrolled;

	// mirror of the console contents and registers
	logic [BYTE_W-1:0] shadow_char [CELLS];
	logic [BYTE_W-1:0] shadow_attr [CELLS];
	int unsigned       shadow_col;
	int unsigned       shadow_row;
	logic [BYTE_W-1:0] shadow_text_attr;

	// predicted results, oldest first
	console_result_t   pending_results [$];

	int unsigned cycle_count;
	int unsigned mismatch_count;
	int unsigned checked_count;
	int unsigned scroll_count;
	int unsigned clear_count;
	int unsigned read_count;
	int unsigned no_gap_left;

	text_console_writer dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.opcode          (opcode),
		.char_code       (char_code),
		.cell_index      (cell_index),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.done            (done),
		.cursor_col      (cursor_col),
		.cursor_row      (cursor_row),
		.cursor_position (cursor_position),
		.cell_char       (cell_char),
		.cell_attr       (cell_attr),
		.scrolled        (scrolled)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending_results.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// console predictor: applies one request to the mirror, returns the result
	// ------------------------------------------------------------------------
	function automatic console_result_t apply_console_request(
		input logic [1:0]        op,
		input logic [BYTE_W-1:0] ch,
		input logic [ADDR_W-1:0] idx
	);
		console_result_t r;
		int unsigned     p;
		r = '0;
		case (op)
			OP_PUT: begin
				if (ch == CH_BACKSPACE) begin
					// left one cell, character wiped, attribute kept
					if (shadow_col > 0) begin
						shadow_col--;
						p = shadow_row * COLUMNS + shadow_col;
						if (p < CELLS)
							shadow_char[p] = '0;
					end
				end else if (ch == CH_CR) begin
					shadow_col = 0;
				end else if (ch == CH_LF) begin
					shadow_col = 0;
					shadow_row++;
				end else begin
					p = shadow_row * COLUMNS + shadow_col;
					if (p < CELLS) begin
						shadow_char[p] = ch;
						shadow_attr[p] = shadow_text_attr;
					end
					shadow_col++;
				end
				// wrap at the right margin
				if (shadow_col >= COLUMNS) begin
					shadow_col = 0;
					shadow_row++;
				end
				// cursor hit the last row: shift rows 1..24 up, blank row 23
				if (shadow_row >= ROWS - 1) begin
					for (int i = 0; i < COLUMNS * (ROWS - 1); i++) begin
						shadow_char[i] = shadow_char[i + COLUMNS];
						shadow_attr[i] = shadow_attr[i + COLUMNS];
					end
					for (int i = (ROWS - 2) * COLUMNS; i < (ROWS - 1) * COLUMNS; i++) begin
						shadow_char[i] = '0;
						shadow_attr[i] = '0;
					end
					shadow_row--;
					r.scr = 1'b1;
					scroll_count++;
				end
			end
			OP_READ: begin
				// out-of-range reads return zero bytes
				if (idx < CELLS) begin
					r.chr = shadow_char[idx];
					r.attr = shadow_attr[idx];
				end
				read_count++;
			end
			OP_CLEAR: begin
				// last row survives a clear
				for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) begin
					shadow_char[i] = '0;
					shadow_attr[i] = '0;
				end
				shadow_col = 0;
				shadow_row = 0;
				clear_count++;
			end
			default: ;
		endcase
		r.col = COL_W'(shadow_col);
		r.row = ROW_W'(shadow_row);
		r.pos = ADDR_W'(shadow_row * COLUMNS + shadow_col);
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// request driver: entered and left at a falling edge; start stays high
	// on return so that back-to-back requests need no extra cycle
	// ------------------------------------------------------------------------
	task automatic send_request(
		input logic [1:0]        op,
		input logic [BYTE_W-1:0] ch,
		input logic [ADDR_W-1:0] idx
	);
		int unsigned gap;
		// random idle gaps, broken up by stretches with none at all
		if (no_gap_left == 0 && $urandom_range(0, 31) == 0)
			no_gap_left = $urandom_range(10, 40);
		if (no_gap_left > 0) begin
			gap = 0;
			no_gap_left--;
		end else begin
			gap = $urandom_range(0, 5);
		end
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start      <= 1'b1;
		opcode     <= op;
		char_code  <= ch;
		cell_index <= idx;
		// taken at the first rising edge that sees busy low
		do
			@(posedge clk);
		while (busy);
		pending_results.push_back(apply_console_request(op, ch, idx));
		@(negedge clk);
	endtask

	// drop start and let every predicted result come back
	task automatic wait_until_idle();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		@(negedge clk);
	endtask

	// attribute register write, only while the block is idle
	task automatic write_text_attr(input logic [BYTE_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		shadow_text_attr = value;
	endtask

	// ------------------------------------------------------------------------
	// result checker: one result per done pulse, the block cannot be stalled
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : check_results
		console_result_t want;
		console_result_t got;
		if (arst_n && done) begin
			got = '{col: cursor_col, row: cursor_row, pos: cursor_position,
				chr: cell_char, attr: cell_attr, scr: scrolled};
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: result with nothing expected: col %0d row %0d",
						$time, got.col, got.row);
			end else begin
				want = pending_results.pop_front();
				checked_count++;
				if (got.col !== want.col || got.row !== want.row ||
						got.pos !== want.pos || got.chr !== want.chr ||
						got.attr !== want.attr || got.scr !== want.scr) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("%0t: result %0d mismatch", $time, checked_count);
						$display("  expected col %0d row %0d pos %0d char %h attr %h scrolled %b",
							want.col, want.row, want.pos, want.chr, want.attr, want.scr);
						$display("  got      col %0d row %0d pos %0d char %h attr %h scrolled %b",
							got.col, got.row, got.pos, got.chr, got.attr, got.scr);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// directed tests
	// ------------------------------------------------------------------------

	// cleared screen after reset, read range limits, ignored opcode
	task automatic test_after_reset();
		send_request(OP_READ, 8'h00, 11'd0);
		send_request(OP_READ, 8'h00, ADDR_W'(CELLS - 1));
		send_request(OP_READ, 8'h00, ADDR_W'(CELLS));
		send_request(OP_READ, 8'hFF, 11'h7FF);
		send_request(OP_UNUSED, 8'hFF, 11'h7FF);
		wait_until_idle();
	endtask

	// printable extremes with the reset attribute and both attribute extremes
	task automatic test_put_and_attr();
		send_request(OP_PUT, 8'h00, 11'd0);
		wait_until_idle();
		write_text_attr(8'h00);
		send_request(OP_PUT, 8'h41, 11'd0);
		wait_until_idle();
		write_text_attr(8'hFF);
		send_request(OP_PUT, 8'hFF, 11'h7FF);
		send_request(OP_PUT, 8'h7E, 11'd0);
		for (int i = 0; i < 4; i++)
			send_request(OP_READ, 8'h00, ADDR_W'(i));
		wait_until_idle();
	endtask

	// backspace mid-line and at column 0, carriage return, line feed
	task automatic test_control_chars();
		send_request(OP_PUT, CH_BACKSPACE, 11'd0);
		send_request(OP_READ, 8'h00, 11'd3);
		send_request(OP_PUT, CH_CR, 11'd0);
		send_request(OP_PUT, CH_BACKSPACE, 11'd0);
		send_request(OP_PUT, CH_LF, 11'd0);
		send_request(OP_PUT, 8'h55, 11'd0);
		send_request(OP_READ, 8'h00, ADDR_W'(COLUMNS));
		wait_until_idle();
	endtask

	// clear blanks the text and homes the cursor
	task automatic test_clear_screen();
		send_request(OP_CLEAR, 8'h00, 11'd0);
		send_request(OP_READ, 8'h00, 11'd0);
		send_request(OP_READ, 8'h00, ADDR_W'(COLUMNS));
		wait_until_idle();
	endtask

	// ------------------------------------------------------------------------
	// weighted random traffic, shared by the random tests
	// ------------------------------------------------------------------------
	task automatic run_console_traffic(
		input int unsigned count,
		input int unsigned w_print,
		input int unsigned w_bs,
		input int unsigned w_cr,
		input int unsigned w_lf,
		input int unsigned w_read,
		input int unsigned w_clear,
		input int unsigned w_unused
	);
		int unsigned        total;
		int unsigned        pick;
		int unsigned        lim_bs;
		int unsigned        lim_cr;
		int unsigned        lim_lf;
		int unsigned        lim_read;
		int unsigned        lim_clear;
		logic [ADDR_W-1:0]  idx;
		total     = w_print + w_bs + w_cr + w_lf + w_read + w_clear + w_unused;
		lim_bs    = w_print + w_bs;
		lim_cr    = lim_bs + w_cr;
		lim_lf    = lim_cr + w_lf;
		lim_read  = lim_lf + w_read;
		lim_clear = lim_read + w_clear;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, total - 1);
			idx  = ADDR_W'($urandom_range(0, 2047));
			if (pick < w_print) begin
				send_request(OP_PUT, BYTE_W'($urandom_range(0, 255)), idx);
			end else if (pick < lim_bs) begin
				send_request(OP_PUT, CH_BACKSPACE, idx);
			end else if (pick < lim_cr) begin
				send_request(OP_PUT, CH_CR, idx);
			end else if (pick < lim_lf) begin
				send_request(OP_PUT, CH_LF, idx);
			end else if (pick < lim_read) begin
				// the current line, anywhere on screen, anywhere in range, or the tail and past it
				case ($urandom_range(0, 3))
					0: idx = ADDR_W'(shadow_row * COLUMNS + $urandom_range(0, COLUMNS - 1));
					1: idx = ADDR_W'($urandom_range(0, CELLS - 1));
					2: idx = ADDR_W'($urandom_range(0, 2047));
					default: idx = ADDR_W'($urandom_range(CELLS - 2 * COLUMNS, 2047));
				endcase
				send_request(OP_READ, BYTE_W'($urandom_range(0, 255)), idx);
			end else if (pick < lim_clear) begin
				send_request(OP_CLEAR, BYTE_W'($urandom_range(0, 255)), idx);
			end else begin
				send_request(OP_UNUSED, BYTE_W'($urandom_range(0, 255)), idx);
			end
		end
		wait_until_idle();
	endtask

	// ordinary typing with edits and the odd clear
	task automatic test_random_text();
		write_text_attr(BYTE_W'($urandom_range(0, 255)));
		run_console_traffic(350, 70, 7, 3, 5, 12, 1, 2);
	endtask

	// line feed heavy: cursor runs down to the row above the last and keeps scrolling
	task automatic test_line_feed_scroll();
		write_text_attr(8'h00);
		run_console_traffic(300, 45, 3, 2, 25, 24, 0, 1);
	endtask

	// long lines with no breaks, so the cursor wraps and scrolls on wrap
	task automatic test_line_wrap();
		write_text_attr(8'hFF);
		run_console_traffic(300, 90, 3, 0, 0, 7, 0, 0);
	endtask

	// everything together at a fresh attribute
	task automatic test_random_mixed();
		write_text_attr(BYTE_W'($urandom_range(1, 254)));
		run_console_traffic(400, 55, 8, 4, 10, 20, 2, 1);
	endtask

	// ------------------------------------------------------------------------
	// run sequence
	// ------------------------------------------------------------------------
	initial begin
		// every input known from time zero while reset is held
		arst_n      = 1'b0;
		start       = 1'b0;
		opcode      = '0;
		char_code   = '0;
		cell_index  = '0;
		cfg_we      = 1'b0;
		cfg_wdata   = '0;
		cycle_count    = 0;
		mismatch_count = 0;
		checked_count  = 0;
		scroll_count   = 0;
		clear_count    = 0;
		read_count     = 0;
		no_gap_left    = 0;
		for (int i = 0; i < CELLS; i++) begin
			shadow_char[i] = '0;
			shadow_attr[i] = '0;
		end
		shadow_col       = 0;
		shadow_row       = 0;
		shadow_text_attr = ATTR_RESET;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// the reset clearing pass keeps busy high; the driver waits it out
		test_after_reset();
		test_put_and_attr();
		test_control_chars();
		test_clear_screen();
		test_random_text();
		test_line_feed_scroll();
		test_line_wrap();
		test_random_mixed();

		// stray results would show up within one scroll time
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			mismatch_count++;
			$display("%0d expected results never arrived", pending_results.size());
		end

		$display("checked %0d requests: %0d scrolls, %0d clears, %0d cell reads",
			checked_count, scroll_count, clear_count, read_count);
		$display("%0d mismatches in %0d cycles", mismatch_count, cycle_count);
		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
